/* rtl/core/cprf_pkg.sv */
`timescale 1ns / 1ps

package cprf_pkg;

  // Register index codes on the config port
  typedef enum logic [2:0] {
    CFG_KP      = 3'd0,
    CFG_KI      = 3'd1,
    CFG_KD      = 3'd2,
    CFG_P_LIM   = 3'd3,
    CFG_I_LIM   = 3'd4,
    CFG_D_LIM   = 3'd5,
    CFG_OUT_LIM = 3'd6
  } cfg_idx_e;

  localparam int unsigned DataW  = 32;
  localparam int unsigned LimW   = 31;
  localparam int unsigned FracSh = 24;
  localparam int unsigned ClampW = 42;  // widest value ever clamped (integral sum)

  localparam logic signed [DataW-1:0] KpReset = 32'sh0180_0000;  // 1.5
  localparam logic signed [DataW-1:0] KiReset = 32'sh0000_0000;
  localparam logic signed [DataW-1:0] KdReset = 32'shFFF0_A3D7;  // -0.06
  localparam logic [LimW-1:0]         LimReset = 31'h0078_0000;  // 120.0

  typedef struct packed {
    logic signed [DataW-1:0] kp;
    logic signed [DataW-1:0] ki;
    logic signed [DataW-1:0] kd;
    logic [LimW-1:0]         p_lim;
    logic [LimW-1:0]         i_lim;
    logic [LimW-1:0]         d_lim;
    logic [LimW-1:0]         out_lim;
  } cfg_t;

  // Raw Q.40 products
  typedef struct packed {
    logic signed [64:0] p_prod;
    logic signed [64:0] i_prod;
    logic signed [63:0] d_prod;
  } prod_t;

  // Clamped Q16.16 terms
  typedef struct packed {
    logic signed [DataW-1:0] p_term;
    logic signed [DataW-1:0] i_term;
    logic signed [DataW-1:0] d_term;
  } terms_t;

  typedef struct packed {
    logic                    hit;
    logic signed [DataW-1:0] val;
  } clamp_t;

  function automatic clamp_t clamp_sym(input logic signed [ClampW-1:0] x,
                                       input logic [LimW-1:0] lim);
    logic signed [ClampW-1:0] lim_s;
    logic signed [ClampW-1:0] neg_s;
    clamp_t                   res;
    lim_s = $signed({{(ClampW-LimW){1'b0}}, lim});
    neg_s = -lim_s;
    if (x > lim_s) begin
      res.hit = 1'b1;
      res.val = lim_s[DataW-1:0];
    end else if (x < neg_s) begin
      res.hit = 1'b1;
      res.val = neg_s[DataW-1:0];
    end else begin
      res.hit = 1'b0;
      res.val = x[DataW-1:0];
    end
    return res;
  endfunction

endpackage

/* rtl/core/cprf_if.sv */
`timescale 1ns / 1ps

interface cprf_in_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  setpoint;
  logic signed [31:0]  measured;
  logic signed [31:0]  rate;

  modport source (output valid, output setpoint, output measured, output rate, input ready);
  modport sink   (input valid, input setpoint, input measured, input rate, output ready);
endinterface

interface cprf_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  drive;
  logic                saturated;

  modport source (output valid, output drive, output saturated, input ready);
  modport sink   (input valid, input drive, input saturated, output ready);
endinterface

/* rtl/core/clamped_pid_rate_feedback.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake        Word
// in_i      in   valid / ready    setpoint, measured, rate (signed Q16.16)
// out_o     out  valid / ready    drive (signed Q16.16), saturated
// cfg       in   cfg_we_i only    cfg_idx_i selects register, cfg_data_i value
//
// One word in per cycle, one word out per cycle, while out_o is not stalled.
// Stage 1 holds the three products (33x32 / 32x32 multipliers), stage 2 the
// clamped terms and the integral update, stage 3 the clamped sum.
// Each stage moves on when it is empty or its successor moves: a bubble frees
// the input even while the output word is stalled.
// Reset clears the valid flags, the integral and restores the register defaults.

module clamped_pid_rate_feedback (
  input  logic        clk_i,
  input  logic        rst_ni,
  cprf_in_if.sink     in_i,
  cprf_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import cprf_pkg::*;

  cfg_t   cfg_q;
  prod_t  prod;
  terms_t terms;
  logic   mul_valid, acc_ready;
  logic   acc_valid, out_ready;

  // Config registers. Bits above a register's width are dropped; index 7 ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp      <= KpReset;
      cfg_q.ki      <= KiReset;
      cfg_q.kd      <= KdReset;
      cfg_q.p_lim   <= LimReset;
      cfg_q.i_lim   <= LimReset;
      cfg_q.d_lim   <= LimReset;
      cfg_q.out_lim <= LimReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_KP:      cfg_q.kp      <= $signed(cfg_data_i);
        CFG_KI:      cfg_q.ki      <= $signed(cfg_data_i);
        CFG_KD:      cfg_q.kd      <= $signed(cfg_data_i);
        CFG_P_LIM:   cfg_q.p_lim   <= cfg_data_i[LimW-1:0];
        CFG_I_LIM:   cfg_q.i_lim   <= cfg_data_i[LimW-1:0];
        CFG_D_LIM:   cfg_q.d_lim   <= cfg_data_i[LimW-1:0];
        CFG_OUT_LIM: cfg_q.out_lim <= cfg_data_i[LimW-1:0];
        default: ;
      endcase
    end
  end

  // error and the three products
  cprf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .cfg_i   (cfg_q),
    .valid_o (mul_valid),
    .ready_i (acc_ready),
    .prod_o  (prod)
  );

  // floor shift, per-term clamps, integral accumulate and clamp
  cprf_acc u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (mul_valid),
    .ready_o (acc_ready),
    .prod_i  (prod),
    .valid_o (acc_valid),
    .ready_i (out_ready),
    .terms_o (terms)
  );

  // sum, output clamp, result register
  cprf_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (acc_valid),
    .ready_o (out_ready),
    .terms_i (terms),
    .out_o   (out_o)
  );

endmodule

/* rtl/core/cprf_mul.sv */
`timescale 1ns / 1ps

module cprf_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  cprf_in_if.sink           in_i,
  input  cprf_pkg::cfg_t    cfg_i,
  output logic              valid_o,
  input  logic              ready_i,
  output cprf_pkg::prod_t   prod_o
);
  import cprf_pkg::*;

  logic signed [32:0] err;
  prod_t              prod_d, prod_q;
  logic               valid_q;
  logic               adv;

  // error kept at 33 bits, never wraps
  assign err = 33'(in_i.setpoint) - 33'(in_i.measured);

  always_comb begin
    prod_d.p_prod = 65'(err) * 65'(cfg_i.kp);
    prod_d.i_prod = 65'(err) * 65'(cfg_i.ki);
    prod_d.d_prod = 64'(in_i.rate) * 64'(cfg_i.kd);
  end

  assign adv        = !valid_q || ready_i;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_i.valid) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

/* rtl/core/cprf_acc.sv */
`timescale 1ns / 1ps

module cprf_acc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cprf_pkg::cfg_t    cfg_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  cprf_pkg::prod_t   prod_i,
  output logic              valid_o,
  input  logic              ready_i,
  output cprf_pkg::terms_t  terms_o
);
  import cprf_pkg::*;

  logic signed [DataW-1:0] integral_q, integral_d;
  logic signed [40:0]      p_sh, i_sh;
  logic signed [39:0]      d_sh;
  logic signed [41:0]      acc;
  clamp_t                  p_c, i_c, d_c;
  terms_t                  terms_q;
  logic                    valid_q;
  logic                    adv;
  logic                    upd;

  // floor divide by 2^24: dropping the low bits of a two's complement value
  assign p_sh = prod_i.p_prod[64:FracSh];
  assign i_sh = prod_i.i_prod[64:FracSh];
  assign d_sh = prod_i.d_prod[63:FracSh];
  assign acc  = 42'(integral_q) + 42'(i_sh);

  always_comb begin
    p_c        = clamp_sym(42'(p_sh), cfg_i.p_lim);
    i_c        = clamp_sym(acc, cfg_i.i_lim);
    d_c        = clamp_sym(42'(d_sh), cfg_i.d_lim);
    integral_d = i_c.val;
  end

  assign adv     = !valid_q || ready_i;
  assign ready_o = adv;
  assign upd     = adv && valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      integral_q <= '0;
    end else begin
      if (adv) begin
        valid_q <= valid_i;
      end
      if (upd) begin
        integral_q <= integral_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      terms_q.p_term <= p_c.val;
      terms_q.i_term <= i_c.val;
      terms_q.d_term <= d_c.val;
    end
  end

  assign valid_o = valid_q;
  assign terms_o = terms_q;

  a_int_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd |=> (33'(integral_q) <= $signed({2'b00, $past(cfg_i.i_lim)}) &&
             33'(integral_q) >= -$signed({2'b00, $past(cfg_i.i_lim)})))
    else $error("integral left its bound after an update");

  a_int_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd |=> $stable(integral_q))
    else $error("integral changed without an accepted word");

endmodule

/* rtl/core/cprf_out.sv */
`timescale 1ns / 1ps

module cprf_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cprf_pkg::cfg_t    cfg_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  cprf_pkg::terms_t  terms_i,
  cprf_out_if.source        out_o
);
  import cprf_pkg::*;

  logic signed [33:0]      sum;
  clamp_t                  sum_c;
  logic signed [DataW-1:0] drive_q;
  logic                    sat_q;
  logic                    valid_q;
  logic                    adv;

  assign sum = 34'(terms_i.p_term) + 34'(terms_i.i_term) + 34'(terms_i.d_term);

  always_comb begin
    sum_c = clamp_sym(42'(sum), cfg_i.out_lim);
  end

  assign adv     = !valid_q || out_o.ready;
  assign ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      drive_q <= sum_c.val;
      sat_q   <= sum_c.hit;
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.drive     = drive_q;
  assign out_o.saturated = sat_q;

  a_drive_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (33'(drive_q) <= $signed({2'b00, cfg_i.out_lim}) &&
                 33'(drive_q) >= -$signed({2'b00, cfg_i.out_lim})))
    else $error("drive outside output limit");

  a_sat_at_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && sat_q) |-> (33'(drive_q) == $signed({2'b00, cfg_i.out_lim}) ||
                            33'(drive_q) == -$signed({2'b00, cfg_i.out_lim})))
    else $error("saturated word not at the output limit");

endmodule

/* bench/tb_clamped_pid_rate_feedback.sv */
`timescale 1ns / 1ps

module tb_clamped_pid_rate_feedback;
  import cprf_pkg::*;

  typedef logic signed [79:0] wide_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               saturated;
  } drive_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  cprf_in_if  in_ch ();
  cprf_out_if out_ch ();

  clamped_pid_rate_feedback dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the registers and of the integral, kept in step with the block
  logic signed [31:0] gain_p = KpReset;
  logic signed [31:0] gain_i = KiReset;
  logic signed [31:0] gain_d = KdReset;
  logic [30:0]        lim_p = LimReset;
  logic [30:0]        lim_i = LimReset;
  logic [30:0]        lim_d = LimReset;
  logic [30:0]        lim_out = LimReset;
  logic signed [31:0] integ_state = '0;

  drive_word_t expected_drives[$];
  int          fault_count = 0;
  int          stall_left = 0;   // receiver hold-off, counted down by the sink
  bit          in_gaps = 1'b1;
  bit          out_gaps = 1'b1;

  // Symmetric clamp at full precision; hit is set when the value was changed
  function automatic wide_t bound_sym(input wide_t x, input logic [30:0] lim,
                                      output logic hit);
    wide_t lw;
    lw  = lim;
    hit = 1'b1;
    if (x > lw) return lw;
    if (x < -lw) return -lw;
    hit = 1'b0;
    return x;
  endfunction

  // One control step: 33 bit error, Q.40 products floored to Q16.16, clamps,
  // integral update, clamped sum. Advances the shadow integral.
  function automatic drive_word_t predict_drive(input logic signed [31:0] sp, ms, rt);
    wide_t       err, p_term, acc, d_term, total;
    logic        hit;
    drive_word_t w;
    err    = sp - ms;
    p_term = bound_sym((err * gain_p) >>> FracSh, lim_p, hit);
    acc    = integ_state + ((err * gain_i) >>> FracSh);
    acc    = bound_sym(acc, lim_i, hit);
    integ_state = acc[31:0];
    d_term = bound_sym((rt * gain_d) >>> FracSh, lim_d, hit);
    total  = bound_sym(p_term + acc + d_term, lim_out, hit);
    w.drive     = total[31:0];
    w.saturated = hit;
    return w;
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3, 4: return $urandom;
      default: return $urandom_range(32'h0800_0000) - 32'h0400_0000;  // +/- 4.0
    endcase
  endfunction

  // Bit 31 is random on purpose: the block must ignore it
  function automatic logic [31:0] rand_limit();
    logic [31:0] v;
    case ($urandom_range(7))
      0: v = '0;
      1: v = 32'hFFFF_FFFF;
      2: v = $urandom;
      default: v = $urandom_range(32'h0100_0000);  // up to 256.0
    endcase
    v[31] = 1'($urandom_range(1));
    return v;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(11))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3, 4: return $urandom;
      default: return $urandom_range(32'h0200_0000) - 32'h0100_0000;  // +/- 256.0
    endcase
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_KP:      gain_p = val;
      CFG_KI:      gain_i = val;
      CFG_KD:      gain_d = val;
      CFG_P_LIM:   lim_p = val[30:0];
      CFG_I_LIM:   lim_i = val[30:0];
      CFG_D_LIM:   lim_d = val[30:0];
      CFG_OUT_LIM: lim_out = val[30:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // valid is left high after acceptance; the next caller re-drives or lowers
  // it in the same step, so a word is never offered twice
  task automatic send_word(input logic [31:0] sp, ms, rt);
    while (in_gaps && $urandom_range(99) < 34) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.setpoint <= sp;
    in_ch.measured <= ms;
    in_ch.rate     <= rt;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_drives.push_back(predict_drive(sp, ms, rt));
  endtask

  // Sender pauses until every outstanding word is back and the pipe is empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic log_fault(input string what, input logic [31:0] want, got);
    fault_count++;
    if (fault_count <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
  endtask

  // Sink: checks each accepted word against the oldest prediction, drives ready
  always @(posedge clk_i) begin : sink_proc
    drive_word_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_drives.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: output word with none outstanding, drive %h", $time, out_ch.drive);
      end else begin
        want = expected_drives.pop_front();
        if (out_ch.drive !== want.drive) log_fault("drive", want.drive, out_ch.drive);
        if (out_ch.saturated !== want.saturated)
          log_fault("saturated", 32'(want.saturated), 32'(out_ch.saturated));
      end
    end
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= !(out_gaps && $urandom_range(99) < 34);
    end
  end

  // Reset gains: PD with default limits; zero, unit step, error overflow both ways
  task automatic test_default_gains();
    send_word(32'h0, 32'h0, 32'h0);
    send_word(32'h0001_0000, 32'h0, 32'h0001_0000);
    send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
  endtask

  // Extreme gains and widest limits, written with the ignored top bit set
  task automatic test_extreme_gains();
    drain();
    write_reg(CFG_KP, 32'h7FFF_FFFF);
    write_reg(CFG_KI, 32'h8000_0000);
    write_reg(CFG_KD, 32'h8000_0000);
    write_reg(CFG_P_LIM, 32'hFFFF_FFFF);
    write_reg(CFG_I_LIM, 32'hFFFF_FFFF);
    write_reg(CFG_D_LIM, 32'hFFFF_FFFF);
    write_reg(CFG_OUT_LIM, 32'hFFFF_FFFF);
    send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    send_word(32'h0, 32'h0, 32'h8000_0000);
  endtask

  // Integral runs into its bound, then the bound is lowered under it
  task automatic test_integral_clamp();
    drain();
    write_reg(CFG_KP, 32'h0);
    write_reg(CFG_KD, 32'h0);
    write_reg(CFG_KI, 32'h0100_0000);
    write_reg(CFG_I_LIM, 32'h000A_0000);
    repeat (3) send_word(32'h0004_0000, 32'h0, 32'h0);
    drain();
    write_reg(CFG_I_LIM, 32'h0003_0000);
    send_word(32'h0, 32'h0, 32'h0);
    send_word(32'h0, 32'h0001_0000, 32'h0);
  endtask

  // Zero limits force their terms to zero; a zero output bound saturates
  task automatic test_zero_limits();
    drain();
    write_reg(CFG_KP, 32'h0100_0000);
    write_reg(CFG_KD, 32'h0100_0000);
    write_reg(CFG_P_LIM, 32'h0);
    write_reg(CFG_I_LIM, 32'h0);
    write_reg(CFG_D_LIM, 32'h0);
    send_word(32'h0005_0000, 32'h0, 32'h0005_0000);
    drain();
    write_reg(CFG_P_LIM, 32'h7FFF_FFFF);
    write_reg(CFG_OUT_LIM, 32'h0);
    send_word(32'h0005_0000, 32'h0, 32'h0);
    send_word(32'h0, 32'h0005_0000, 32'h0);
  endtask

  // Sum exactly on the output bound is passed, one LSB beyond is clamped
  task automatic test_output_clamp();
    drain();
    write_reg(CFG_KI, 32'h0);
    write_reg(CFG_KD, 32'h0);
    write_reg(CFG_P_LIM, 32'h0064_0000);
    write_reg(CFG_OUT_LIM, 32'h0005_0000);
    send_word(32'h0005_0000, 32'h0, 32'h0);
    send_word(32'h0005_0001, 32'h0, 32'h0);
    send_word(32'h0, 32'h0005_0000, 32'h0);
    send_word(32'h0, 32'h0005_0001, 32'h0);
  endtask

  // Several random settings, each followed by a run of random words
  task automatic test_random_settings();
    for (int phase = 0; phase < 7; phase++) begin
      drain();
      write_reg(CFG_KP, rand_gain());
      write_reg(CFG_KI, rand_gain());
      write_reg(CFG_KD, rand_gain());
      write_reg(CFG_P_LIM, rand_limit());
      write_reg(CFG_I_LIM, rand_limit());
      write_reg(CFG_D_LIM, rand_limit());
      write_reg(CFG_OUT_LIM, rand_limit());
      repeat (120) send_word(rand_value(), rand_value(), rand_value());
    end
  endtask

  // Receiver holds off for a long while; sender keeps offering until input stalls
  task automatic test_backpressure();
    drain();
    write_reg(CFG_KP, 32'h0100_0000);
    write_reg(CFG_KI, 32'h0008_0000);
    write_reg(CFG_KD, 32'hFFF0_0000);
    write_reg(CFG_P_LIM, 32'h0200_0000);
    write_reg(CFG_I_LIM, 32'h0100_0000);
    write_reg(CFG_D_LIM, 32'h0080_0000);
    write_reg(CFG_OUT_LIM, 32'h0300_0000);
    in_gaps    = 1'b0;
    stall_left = 400;
    repeat (80) send_word(rand_value(), rand_value(), rand_value());
    in_gaps = 1'b1;
  endtask

  // Long stretch with no idling on either side
  task automatic test_unbroken_flow();
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    repeat (250) send_word(rand_value(), rand_value(), rand_value());
    in_gaps  = 1'b1;
    out_gaps = 1'b1;
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.setpoint = '0;
    in_ch.measured = '0;
    in_ch.rate     = '0;
    out_ch.ready   = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_KP;
    cfg_data_i     = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_gains();
    test_extreme_gains();
    test_integral_clamp();
    test_zero_limits();
    test_output_clamp();
    test_random_settings();
    test_backpressure();
    test_unbroken_flow();

    drain();
    repeat (10) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
